// ===== hdl/binned_interval_coverage_core_assert.svh =====
// assertion macros for the binned interval coverage core
`ifndef BINNED_INTERVAL_COVERAGE_CORE_ASSERT_SVH
`define BINNED_INTERVAL_COVERAGE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define BIC_ASSERT_IMP(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication, disabled in reset
`define BIC_ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define BIC_ASSERT_IMP(lbl, clk, rst, a, b, msg)
`define BIC_ASSERT_NEXT(lbl, clk, rst, a, b, msg)
`endif

`endif

// ===== hdl/bic_pkg.sv =====
// shared types and constants for the binned interval coverage core
`timescale 1ns / 1ps
`default_nettype none
package bic_pkg;

  localparam int NUM_BINS_DEF    = 4096;
  localparam int COUNT_WIDTH_DEF = 32;

  // divider operand widths
  localparam int DIV_W  = 32;
  localparam int DVSR_W = 21;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_BIN_SIZE   = 2'd0;
  localparam logic [1:0] REG_REF_LENGTH = 2'd1;
  localparam logic [1:0] REG_TARGET_REF = 2'd2;

  localparam logic [20:0] BIN_SIZE_RST   = 21'd1000;
  localparam logic [30:0] REF_LENGTH_RST = 31'd1000;
  localparam logic [15:0] TARGET_REF_RST = 16'd0;

  localparam logic [15:0] REJECT_MASK = 16'h0904;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FLAG      = 3'd1;
  localparam logic [2:0] ST_OTHER_REF = 3'd2;
  localparam logic [2:0] ST_OUTSIDE   = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIV_USED  = 2'd0,
    DIV_FIRST = 2'd1,
    DIV_LAST  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic [20:0] bin_size;
    logic [30:0] ref_len;
    logic [15:0] target;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic       div_capture;
    div_sel_t   div_sel;
    logic       span_init;
    logic       rd_span;
    logic       rd_bin;
    logic       wr_inc;
    logic       cur_step;
    logic       clr_step;
    logic       load_result;
    logic [2:0] res_status;
    logic       res_read;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       flag_reject;
    logic       ref_mismatch;
    logic       interval_bad;
    logic       div_done;
    logic       div_busy;
    logic       beyond;
    logic       span_last;
    logic       clear_last;
    logic       read_in_store;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/bic_if.sv =====
// item and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface bic_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] start_pos;
  logic signed [31:0] end_pos;
  logic [15:0]        align_flags;
  logic signed [16:0] reference_id;
  logic [11:0]        read_bin;

  modport source (output valid, kind, start_pos, end_pos, align_flags, reference_id,
                  read_bin, input ready);
  modport sink (input valid, kind, start_pos, end_pos, align_flags, reference_id,
                read_bin, output ready);
endinterface

interface bic_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] bin_count;

  modport source (output valid, status, bin_count, input ready);
  modport sink (input valid, status, bin_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/bic_cfg.sv =====
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none
module bic_cfg import bic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bin_size <= BIN_SIZE_RST;
      cfg.ref_len  <= REF_LENGTH_RST;
      cfg.target   <= TARGET_REF_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BIN_SIZE:   cfg.bin_size <= pwdata[20:0];
        REG_REF_LENGTH: cfg.ref_len  <= pwdata[30:0];
        REG_TARGET_REF: cfg.target   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BIN_SIZE:   prdata = CFG_DW'(cfg.bin_size);
      REG_REF_LENGTH: prdata = CFG_DW'(cfg.ref_len);
      REG_TARGET_REF: prdata = CFG_DW'(cfg.target);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/bic_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bic_divider import bic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [DVSR_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic      [DIV_W-1:0]  quotient
);

  localparam int CW = $clog2(DIV_W);

  logic [CW-1:0]     cnt;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvs;
  logic [DIV_W-1:0]  quo;
  logic [DVSR_W:0]   trial;
  logic              fits;

  assign trial    = {rem, quo[DIV_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so the top trial bit drops out
      if (fits) begin
        rem <= DVSR_W'(trial - {1'b0, dvs});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[DVSR_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bic_datapath.sv =====
// datapath: item registers, bin arithmetic, coverage memory, result register
`timescale 1ns / 1ps
`default_nettype none
module bic_datapath import bic_pkg::*; #(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] start_pos,
  input  wire logic signed [31:0] end_pos,
  input  wire logic [15:0]        align_flags,
  input  wire logic signed [16:0] reference_id,
  input  wire logic [11:0]        read_bin,
  input  wire ctl_cmd_t           ctl,
  output dp_stat_t                stat,
  output logic [2:0]              res_status,
  output logic [31:0]             res_count
);

  localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int USED_W = $clog2(NUM_BINS + 1);
  localparam logic [31:0] NB32 = 32'(NUM_BINS);

  // captured item
  logic [1:0]         it_kind;
  logic signed [31:0] it_start;
  logic signed [31:0] it_end;
  logic [15:0]        it_flags;
  logic signed [16:0] it_ref;
  logic [11:0]        it_bin;

  logic [DVSR_W-1:0] bs_eff;
  logic [DIV_W-1:0]  dividend;
  logic              div_busy;
  logic              div_done;
  logic [DIV_W-1:0]  quotient;

  logic [USED_W-1:0] used_q;
  logic [31:0]       first_q;
  logic [31:0]       last_q;
  logic [31:0]       used32;
  logic [31:0]       used_m1;
  logic [31:0]       rb32;

  logic [ADDR_W-1:0] cur;
  logic [ADDR_W-1:0] last_b;
  logic [ADDR_W-1:0] clr_ptr;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic                   we;
  logic                   re;
  logic [63:0]            wide;
  logic [31:0]            count32;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      it_kind  <= kind;
      it_start <= start_pos;
      it_end   <= end_pos;
      it_flags <= align_flags;
      it_ref   <= reference_id;
      it_bin   <= read_bin;
    end
  end

  assign bs_eff = (cfg.bin_size == '0) ? DVSR_W'(1) : cfg.bin_size;

  always_comb begin
    case (ctl.div_sel)
      DIV_USED:  dividend = 32'(cfg.ref_len) + 32'(bs_eff) - 32'd1;
      DIV_FIRST: dividend = $unsigned(it_start);
      DIV_LAST:  dividend = $unsigned(it_end - 32'sd1);
      default:   dividend = '0;
    endcase
  end

  bic_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (dividend),
    .divisor  (bs_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (ctl.div_capture) begin
      case (ctl.div_sel)
        DIV_USED:  used_q  <= (quotient >= NB32) ? USED_W'(NUM_BINS) : quotient[USED_W-1:0];
        DIV_FIRST: first_q <= quotient;
        default:   last_q  <= quotient;
      endcase
    end
  end

  assign used32  = 32'(used_q);
  assign used_m1 = used32 - 32'd1;
  assign rb32    = 32'(it_bin);

  // span walk pointers
  always_ff @(posedge clk) begin
    if (ctl.span_init) begin
      cur    <= first_q[ADDR_W-1:0];
      last_b <= (last_q >= used32) ? used_m1[ADDR_W-1:0] : last_q[ADDR_W-1:0];
    end else if (ctl.cur_step) begin
      cur <= cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (ctl.clr_step) begin
      clr_ptr <= stat.clear_last ? '0 : clr_ptr + 1'b1;
    end
  end

  // single write port, single registered read port
  always_comb begin
    we    = ctl.clr_step || ctl.wr_inc;
    waddr = ctl.clr_step ? clr_ptr : cur;
    wdata = ctl.clr_step ? '0 : ((rd_data == '1) ? rd_data : rd_data + 1'b1);
    re    = ctl.rd_span || ctl.rd_bin;
    raddr = ctl.rd_span ? cur : rb32[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_comb begin
    wide                    = '0;
    wide[COUNT_WIDTH-1:0]   = rd_data;
    count32                 = wide[31:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      res_status <= ctl.res_status;
      res_count  <= ctl.res_read ? count32 : '0;
    end
  end

  always_comb begin
    stat.kind          = it_kind;
    stat.flag_reject   = |(it_flags & REJECT_MASK);
    stat.ref_mismatch  = $unsigned(it_ref) != {1'b0, cfg.target};
    stat.interval_bad  = (it_start < 0) || (it_end <= it_start);
    stat.div_done      = div_done;
    stat.div_busy      = div_busy;
    stat.beyond        = first_q >= used32;
    stat.span_last     = cur == last_b;
    stat.clear_last    = clr_ptr == ADDR_W'(NUM_BINS - 1);
    stat.read_in_store = rb32 < NB32;
  end

endmodule
`default_nettype wire

// ===== hdl/bic_ctrl.sv =====
// controller: sequences checks, divisions, bin walk, clearing and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module bic_ctrl import bic_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_ready,
  output logic          out_valid,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      ctl
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RANGE,
    S_RD,
    S_RMW,
    S_RDBIN,
    S_DONE
  } state_t;

  state_t     state;
  logic [2:0] status_code;
  div_sel_t   div_sel;
  logic       clear_item;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = state == S_IDLE;

  always_comb begin
    ctl             = '0;
    ctl.capture     = (state == S_IDLE) && in_valid;
    ctl.div_start   = state == S_DIV_GO;
    ctl.div_capture = (state == S_DIV_WAIT) && stat.div_done;
    ctl.div_sel     = div_sel;
    ctl.span_init   = (state == S_RANGE) && !stat.beyond;
    ctl.rd_span     = state == S_RD;
    ctl.wr_inc      = state == S_RMW;
    ctl.cur_step    = (state == S_RMW) && !stat.span_last;
    ctl.clr_step    = state == S_CLEAR;
    ctl.rd_bin      = state == S_RDBIN;
    ctl.load_result = (state == S_DONE) && slot_free;
    ctl.res_status  = status_code;
    ctl.res_read    = (status_code == ST_READ) && stat.read_in_store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      out_valid   <= 1'b0;
      status_code <= ST_OUTSIDE;
      div_sel     <= DIV_USED;
      clear_item  <= 1'b0;
    end else begin
      // a new result loaded in the same cycle keeps valid high
      if (out_valid && out_ready && !((state == S_DONE) && slot_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (stat.clear_last) begin
            state      <= clear_item ? S_DONE : S_IDLE;
            clear_item <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (stat.kind)
            KIND_ADD: begin
              // flags first, then reference, then the interval
              if (stat.flag_reject) begin
                status_code <= ST_FLAG;
                state       <= S_DONE;
              end else if (stat.ref_mismatch) begin
                status_code <= ST_OTHER_REF;
                state       <= S_DONE;
              end else if (stat.interval_bad) begin
                status_code <= ST_OUTSIDE;
                state       <= S_DONE;
              end else begin
                div_sel <= DIV_USED;
                state   <= S_DIV_GO;
              end
            end
            KIND_READ: begin
              status_code <= ST_READ;
              state       <= S_RDBIN;
            end
            KIND_CLEAR: begin
              status_code <= ST_CLEARED;
              clear_item  <= 1'b1;
              state       <= S_CLEAR;
            end
            default: begin
              status_code <= ST_OUTSIDE;
              state       <= S_DONE;
            end
          endcase
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            case (div_sel)
              DIV_USED: begin
                div_sel <= DIV_FIRST;
                state   <= S_DIV_GO;
              end
              DIV_FIRST: begin
                div_sel <= DIV_LAST;
                state   <= S_DIV_GO;
              end
              default: begin
                state <= S_RANGE;
              end
            endcase
          end
        end
        S_RANGE: begin
          if (stat.beyond) begin
            status_code <= ST_OUTSIDE;
            state       <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_RMW;
        end
        S_RMW: begin
          if (stat.span_last) begin
            status_code <= ST_ADDED;
            state       <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_RDBIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/binned_interval_coverage_core.sv =====
// binned read coverage histogram: top level
// Items enter on cmd (valid/ready) and each one gives exactly one item on result.
// kind add: the alignment is checked (flags, reference, interval), then three
//   divisions by the bin size on a shared one-bit-per-cycle divider give the
//   bins in use, the first and the last bin; each touched bin then takes a
//   read-modify-write on the coverage memory (one write and one read port).
//   A rejected item skips the divisions and goes straight to its result.
// kind read: one registered memory read.
// kind clear: the memory is zeroed one entry per cycle.
// One item is worked on at a time; the next is taken as soon as the controller
// is back in idle, while the finished result can still wait in the output register.
// A stalled result holds; the controller waits for that register before handing
// over the next result.
// Reset (synchronous, active high) returns the registers to their defaults and
// starts a clearing pass over all NUM_BINS entries; cmd.ready stays low during it,
// the configuration port is served throughout.
// Registers: bin_size at 0x0, reference_length at 0x4, target_reference at 0x8.
`timescale 1ns / 1ps
`default_nettype none
`include "binned_interval_coverage_core_assert.svh"
module binned_interval_coverage_core import bic_pkg::*; #(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  bic_item_if.sink               cmd,
  bic_result_if.source           result
);

  cfg_t     cfg;
  ctl_cmd_t ctl;
  dp_stat_t dp_st;
  logic     res_free;

  bic_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .stat      (dp_st),
    .ctl       (ctl)
  );

  bic_datapath #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .kind         (cmd.kind),
    .start_pos    (cmd.start_pos),
    .end_pos      (cmd.end_pos),
    .align_flags  (cmd.align_flags),
    .reference_id (cmd.reference_id),
    .read_bin     (cmd.read_bin),
    .ctl          (ctl),
    .stat         (dp_st),
    .res_status   (result.status),
    .res_count    (result.bin_count)
  );

  assign res_free = !result.valid || result.ready;

  `BIC_ASSERT_IMP(a_no_accept_clr, clk, rst, ctl.clr_step, !cmd.ready, "ready in clear")
  `BIC_ASSERT_IMP(a_slot_free, clk, rst, ctl.load_result, res_free, "result overwritten")
  `BIC_ASSERT_NEXT(a_div_runs, clk, rst, ctl.div_start, dp_st.div_busy, "divider did not start")

endmodule
`default_nettype wire
